FILE: rtl/sio_cfg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sio_cfg_pkg;

   localparam int PtrWidth      = 5;
   localparam int StoredRegs    = 8;   // registers 0..7 hold bytes; 8 is read-only
   localparam int RegIdxWidth   = 3;
   localparam int DefReadable   = 14;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 2;
   localparam int RspDataWidth  = 80;

   // configuration register indexes
   localparam logic [CsrIndexWidth-1:0] CSR_CHIP_VARIANT = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_IDE_CHANNEL  = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_FDC_ON       = 2'd2;

   // access kinds
   localparam logic ACT_READ   = 1'b0;
   localparam logic ACT_WRITE  = 1'b1;
   localparam logic PORT_INDEX = 1'b0;
   localparam logic PORT_DATA  = 1'b1;

   // IDE channel codes
   localparam logic [1:0] IDE_PRIMARY   = 2'd1;
   localparam logic [1:0] IDE_SECONDARY = 2'd2;

   localparam logic [PtrWidth-1:0] PTR_READ_ONLY = 5'd8;
   localparam logic [7:0]          RD_REG8       = 8'h10;
   localparam logic [7:0]          RD_NONE       = 8'hFF;

   typedef logic [7:0] byte_type;

   // fields packed from the top down so read_data lands in the lowest bits
   typedef struct packed {
      logic [1:0] pad;
      logic [9:0] ide_base;
      logic [9:0] fdc_base;
      logic [3:0] uart_b_irq;
      logic [9:0] uart_b_base;
      logic [3:0] uart_a_irq;
      logic [9:0] uart_a_base;
      logic [2:0] lpt_modes;
      logic [3:0] lpt_irq;
      logic [9:0] lpt_base;
      logic [4:0] enables;
      logic [7:0] read_data;
   } rsp_type;

   typedef struct packed {
      logic [9:0] base;
      logic [3:0] irq;
   } uart_dec_type;

   function automatic byte_type reset_byte(input logic [RegIdxWidth-1:0] idx,
                                           input logic [1:0] ide_ch,
                                           input logic fdc_on);
      byte_type b;
      case (idx)
         3'd0: begin
            b = fdc_on ? 8'h4F : 8'h07;
            if (ide_ch == IDE_SECONDARY) b[7] = 1'b1;
         end
         3'd1:    b = 8'h10;
         3'd3:    b = 8'h01;
         3'd5:    b = 8'h0D;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic uart_dec_type decode_uart(input logic [1:0] sel,
                                                input logic [1:0] alt);
      uart_dec_type d;
      case (sel)
         2'd0: d = '{base: 10'h3F8, irq: 4'd4};
         2'd1: d = '{base: 10'h2F8, irq: 4'd3};
         2'd2: begin
            d.irq = 4'd4;
            case (alt)
               2'd0:    d.base = 10'h3E8;
               2'd1:    d.base = 10'h338;
               2'd2:    d.base = 10'h2E8;
               default: d.base = 10'h220;
            endcase
         end
         default: begin
            d.irq = 4'd3;
            case (alt)
               2'd0:    d.base = 10'h2E8;
               2'd1:    d.base = 10'h238;
               2'd2:    d.base = 10'h2E0;
               default: d.base = 10'h228;
            endcase
         end
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/superio_config_register_file.sv
`timescale 1ns / 1ps
`default_nettype none

// Index/data configuration register file of a small super I/O controller.
// req_ carries one host bus access per transaction: tuser says read or write
// and index or data port, tdata carries the byte written. rsp_ returns one
// transaction per access: the byte read plus the function enables, I/O bases
// and IRQs that the register contents select after that access.
// A data write lands only as the second of two data writes in a row.
// The access is decoded combinationally from the register state into the
// response register (or the skid register while rsp_ stalls), so one
// transaction is accepted every cycle while req_tready is high.
// A two-entry output stage (response register plus skid register) lets a
// new access in while a response waits; req_tready drops only while the
// skid register is full, i.e. once a second access has been taken behind a
// stalled response, and rises the cycle after rsp_ takes a transaction.
// Reset (synchronous, active high) loads the straps with their defaults,
// reruns the register defaults, clears pointer and unlock, and empties the
// output stage. A csr_ write to index 0..2 reloads the register defaults
// in the same way and is expected only while no transaction is outstanding.
module superio_config_register_file
   import sio_cfg_pkg::*;
#(
   parameter int READABLE_REGS = DefReadable
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output      logic                     req_tready,
   input  wire logic [7:0]               req_tdata,   // [7:0] write_data
   input  wire logic [1:0]               req_tuser,   // [0] action, [1] port_select
   output      logic                     rsp_tvalid,
   input  wire logic                     rsp_tready,
   // [7:0] read_data, [12:8] enables, [22:13] lpt_base, [26:23] lpt_irq,
   // [29:27] lpt_modes, [39:30] uart_a_base, [43:40] uart_a_irq,
   // [53:44] uart_b_base, [57:54] uart_b_irq, [67:58] fdc_base, [77:68] ide_base
   output      logic [RspDataWidth-1:0]  rsp_tdata,
   input  wire logic                     csr_we,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_wdata
);

   localparam logic [PtrWidth:0] ReadableLimit = (PtrWidth+1)'(READABLE_REGS);

   // straps
   logic       variant_ff, variant_in;
   logic [1:0] ide_ch_ff,  ide_ch_in;
   logic       fdc_on_ff,  fdc_on_in;

   // register state
   byte_type              regs_ff [StoredRegs];
   byte_type              regs_in [StoredRegs];
   logic [PtrWidth-1:0]   ptr_ff,    ptr_in;
   logic                  unlock_ff, unlock_in;

   // output stage
   rsp_type out_ff,       out_in;
   rsp_type skid_ff,      skid_in;
   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;

   logic     req_take, rsp_take, cfg_hit, wr_ok;
   logic     act, port;
   byte_type rd_byte;
   rsp_type  rsp_new;
   uart_dec_type ua, ub;
   byte_type r0, r1, r2, r4;
   logic     ide_ok;

   assign req_tready = ~skid_valid_ff;
   assign req_take   = req_tvalid & req_tready;
   assign rsp_take   = out_valid_ff & rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;
   assign act        = req_tuser[0];
   assign port       = req_tuser[1];

   assign cfg_hit = csr_we & ((csr_index == CSR_CHIP_VARIANT) ||
                              (csr_index == CSR_IDE_CHANNEL)  ||
                              (csr_index == CSR_FDC_ON));

   // writable: pointer within 0..7, and 0..2 on the small variant
   assign wr_ok = (ptr_ff[PtrWidth-1:RegIdxWidth] == '0) &&
                  (variant_ff || (ptr_ff[RegIdxWidth-1:0] <= 3'd2));

   // access or strap write: straps, pointer, unlock, register bytes and read byte
   always_comb begin
      variant_in = variant_ff;
      ide_ch_in  = ide_ch_ff;
      fdc_on_in  = fdc_on_ff;
      ptr_in     = ptr_ff;
      unlock_in  = unlock_ff;
      regs_in    = regs_ff;
      rd_byte    = '0;

      if (cfg_hit) begin
         case (csr_index)
            CSR_CHIP_VARIANT: variant_in = csr_wdata[0];
            CSR_IDE_CHANNEL:  ide_ch_in  = csr_wdata;
            CSR_FDC_ON:       fdc_on_in  = csr_wdata[0];
            default:          variant_in = variant_ff;
         endcase
         for (int i = 0; i < StoredRegs; i++) begin
            regs_in[i] = reset_byte(RegIdxWidth'(i), ide_ch_in, fdc_on_in);
         end
         ptr_in    = '0;
         unlock_in = 1'b0;
      end else if (req_take) begin
         if (act == ACT_WRITE) begin
            if (port == PORT_INDEX) begin
               ptr_in    = req_tdata[PtrWidth-1:0];
               unlock_in = 1'b0;
            end else if (unlock_ff) begin
               unlock_in = 1'b0;
               if (wr_ok) regs_in[ptr_ff[RegIdxWidth-1:0]] = req_tdata;
            end else begin
               unlock_in = 1'b1;
            end
         end else begin
            unlock_in = 1'b0;
            if (port == PORT_INDEX)
               rd_byte = {3'b000, ptr_ff};
            else if (ptr_ff == PTR_READ_ONLY)
               rd_byte = RD_REG8;
            else if (ptr_ff[PtrWidth-1:RegIdxWidth] == '0)
               rd_byte = regs_ff[ptr_ff[RegIdxWidth-1:0]];
            else if ({1'b0, ptr_ff} < ReadableLimit)
               rd_byte = '0;       // implemented but never written
            else
               rd_byte = RD_NONE;
         end
      end
   end

   // decode of the function settings after the access
   always_comb begin
      r0     = regs_in[0];
      r1     = regs_in[1];
      r2     = regs_in[2];
      r4     = regs_in[4];
      ide_ok = (ide_ch_ff == IDE_PRIMARY) || (ide_ch_ff == IDE_SECONDARY);
      ua     = decode_uart(r1[3:2], r1[7:6]);
      ub     = decode_uart(r1[5:4], r1[7:6]);

      rsp_new           = '0;
      rsp_new.read_data = rd_byte;
      // power-down bit kills everything but IDE
      rsp_new.enables[3:0] = r2[0] ? 4'h0 : r0[3:0];
      rsp_new.enables[4]   = ide_ok & r0[6];

      case (r1[1:0])
         2'd0: begin
            rsp_new.lpt_base = 10'h378;
            rsp_new.lpt_irq  = r2[3] ? 4'd7 : 4'd5;
         end
         2'd1: begin
            rsp_new.lpt_base = 10'h3BC;
            rsp_new.lpt_irq  = 4'd7;
         end
         2'd2: begin
            rsp_new.lpt_base = 10'h278;
            rsp_new.lpt_irq  = 4'd5;
         end
         default: begin
            rsp_new.lpt_base = '0;
            rsp_new.lpt_irq  = '0;
         end
      endcase

      rsp_new.lpt_modes   = {variant_ff & r4[2], variant_ff & r4[0], r2[7]};
      rsp_new.uart_a_base = ua.base;
      rsp_new.uart_a_irq  = ua.irq;
      rsp_new.uart_b_base = ub.base;
      rsp_new.uart_b_irq  = ub.irq;
      rsp_new.fdc_base    = r0[5] ? 10'h370 : 10'h3F0;
      rsp_new.ide_base    = ide_ok ? (r0[7] ? 10'h170 : 10'h1F0) : 10'h000;
   end

   // output register plus skid register
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (rsp_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_take) begin
         if (!out_valid_ff || rsp_tready) begin
            out_in       = rsp_new;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = rsp_new;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
      if (reset) begin
         variant_ff    <= 1'b0;
         ide_ch_ff     <= 2'd0;
         fdc_on_ff     <= 1'b1;
         for (int i = 0; i < StoredRegs; i++) begin
            regs_ff[i] <= reset_byte(RegIdxWidth'(i), 2'd0, 1'b1);
         end
         ptr_ff        <= '0;
         unlock_ff     <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         variant_ff    <= variant_in;
         ide_ch_ff     <= ide_ch_in;
         fdc_on_ff     <= fdc_on_in;
         regs_ff       <= regs_in;
         ptr_ff        <= ptr_in;
         unlock_ff     <= unlock_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps

// Bench for the super I/O index/data configuration register file.
// Host accesses go in on req_ (tuser = {port_select, action}, tdata = byte)
// and every transaction returns exactly one rsp_ transaction: the byte read
// plus the decoded enables, bases and IRQs. A local copy of the register
// state predicts each reply at the moment the access is accepted; replies
// are checked in order, field by field, as they leave rsp_.
module testbench
   import sio_cfg_pkg::*;
();

   localparam int ReadableRegs = DefReadable;
   localparam int LongHold     = 40;   // cycles rsp_tready is held off under pressure
   localparam int PrintLimit   = 40;

   // strap codes the package does not name
   localparam logic [CsrIndexWidth-1:0] CSR_UNUSED  = 2'd3;   // not in the list
   localparam logic [1:0]               IDE_NONE    = 2'd0;
   localparam logic [1:0]               IDE_INVALID = 2'd3;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_tvalid  = 1'b0;
   logic                     req_tready;
   logic [7:0]               req_tdata   = '0;   // [7:0] write_data
   logic [1:0]               req_tuser   = '0;   // [0] action, [1] port_select
   logic                     rsp_tvalid;
   logic                     rsp_tready  = 1'b0;
   // [7:0] read_data, [12:8] enables, [22:13] lpt_base, [26:23] lpt_irq,
   // [29:27] lpt_modes, [39:30] uart_a_base, [43:40] uart_a_irq,
   // [53:44] uart_b_base, [57:54] uart_b_irq, [67:58] fdc_base, [77:68] ide_base
   logic [RspDataWidth-1:0]  rsp_tdata;
   logic                     csr_we      = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index   = '0;
   logic [CsrDataWidth-1:0]  csr_wdata   = '0;

   superio_config_register_file dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // run limit, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Shadow of the chip: straps, register bytes, index pointer, unlock flag
   // ---------------------------------------------------------------------
   logic       strap_large;
   logic [1:0] strap_ide;
   logic       strap_fdc;
   byte_type   cfg_reg [ReadableRegs];
   logic [4:0] index_ptr;
   logic       arm_pending;

   rsp_type    access_replies [$];   // replies owed, oldest first

   int error_count    = 0;
   int accesses_sent  = 0;
   int replies_seen   = 0;
   int strap_writes   = 0;
   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int hold_token     = 0;
   int hold_seen      = 0;
   int stall_left     = 0;

   // register contents a strap write or reset brings back
   task automatic reload_defaults();
      foreach (cfg_reg[i]) cfg_reg[i] = '0;
      cfg_reg[0] = strap_fdc ? 8'h4F : 8'h07;
      if (strap_ide == IDE_SECONDARY) cfg_reg[0][7] = 1'b1;
      cfg_reg[1] = 8'h10;
      cfg_reg[3] = 8'h01;
      cfg_reg[5] = 8'h0D;
      cfg_reg[8] = 8'h70;
      index_ptr   = '0;
      arm_pending = 1'b0;
   endtask

   // serial port select/alternate bits -> {base, irq}
   function automatic logic [13:0] uart_map(input logic [1:0] sel,
                                            input logic [1:0] alt);
      case (sel)
         2'd0: return {10'h3F8, 4'd4};
         2'd1: return {10'h2F8, 4'd3};
         2'd2: begin
            case (alt)
               2'd0:    return {10'h3E8, 4'd4};
               2'd1:    return {10'h338, 4'd4};
               2'd2:    return {10'h2E8, 4'd4};
               default: return {10'h220, 4'd4};
            endcase
         end
         default: begin
            case (alt)
               2'd0:    return {10'h2E8, 4'd3};
               2'd1:    return {10'h238, 4'd3};
               2'd2:    return {10'h2E0, 4'd3};
               default: return {10'h228, 4'd3};
            endcase
         end
      endcase
   endfunction

   // apply one host access to the shadow and decode what the chip reports
   function automatic rsp_type host_access(input logic act, input logic port,
                                           input byte_type wdata);
      rsp_type    r;
      byte_type   r0, r1, r2, r4;
      logic [4:0] top_reg;
      logic       ide_live;
      r       = '0;
      top_reg = strap_large ? 5'd8 : 5'd2;
      if (act == ACT_WRITE) begin
         if (port == PORT_INDEX) begin
            index_ptr   = wdata[4:0];
            arm_pending = 1'b0;
         end else if (arm_pending) begin
            // second write of the pair lands, unless read-only or beyond the chip
            arm_pending = 1'b0;
            if (index_ptr <= top_reg && index_ptr != PTR_READ_ONLY)
               cfg_reg[index_ptr] = wdata;
         end else begin
            arm_pending = 1'b1;
         end
      end else begin
         arm_pending = 1'b0;
         if (port == PORT_INDEX)
            r.read_data = {3'b000, index_ptr};
         else if (index_ptr == PTR_READ_ONLY)
            r.read_data = RD_REG8;
         else if (index_ptr < ReadableRegs)
            r.read_data = cfg_reg[index_ptr];
         else
            r.read_data = RD_NONE;
      end

      r0 = cfg_reg[0];
      r1 = cfg_reg[1];
      r2 = cfg_reg[2];
      r4 = cfg_reg[4];
      ide_live = (strap_ide == IDE_PRIMARY) || (strap_ide == IDE_SECONDARY);

      // power-down kills everything but IDE
      r.enables = r2[0] ? 5'd0 : {1'b0, r0[3:0]};
      if (ide_live && r0[6]) r.enables[4] = 1'b1;

      case (r1[1:0])
         2'd0: begin
            r.lpt_base = 10'h378;
            r.lpt_irq  = r2[3] ? 4'd7 : 4'd5;
         end
         2'd1: begin
            r.lpt_base = 10'h3BC;
            r.lpt_irq  = 4'd7;
         end
         2'd2: begin
            r.lpt_base = 10'h278;
            r.lpt_irq  = 4'd5;
         end
         default: begin
            r.lpt_base = 10'h000;
            r.lpt_irq  = 4'd0;
         end
      endcase
      r.lpt_modes = {strap_large & r4[2], strap_large & r4[0], r2[7]};

      {r.uart_a_base, r.uart_a_irq} = uart_map(r1[3:2], r1[7:6]);
      {r.uart_b_base, r.uart_b_irq} = uart_map(r1[5:4], r1[7:6]);

      r.fdc_base = r0[5] ? 10'h370 : 10'h3F0;
      r.ide_base = ide_live ? (r0[7] ? 10'h170 : 10'h1F0) : 10'h000;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [79:0] got,
                                  input logic [79:0] want);
      if (error_count < PrintLimit)
         $display("ERROR @%0t reply %0d: %s got 0x%0h want 0x%0h",
                  $time, replies_seen, what, got, want);
      error_count++;
   endtask

   task automatic check_reply(input rsp_type got);
      rsp_type want;
      replies_seen++;
      if (access_replies.size() == 0) begin
         report_mismatch("transaction with nothing owed", got, '0);
         return;
      end
      want = access_replies.pop_front();
      if (got.read_data !== want.read_data)
         report_mismatch("read_data", 80'(got.read_data), 80'(want.read_data));
      if (got.enables !== want.enables)
         report_mismatch("enables", 80'(got.enables), 80'(want.enables));
      if (got.lpt_base !== want.lpt_base)
         report_mismatch("lpt_base", 80'(got.lpt_base), 80'(want.lpt_base));
      if (got.lpt_irq !== want.lpt_irq)
         report_mismatch("lpt_irq", 80'(got.lpt_irq), 80'(want.lpt_irq));
      if (got.lpt_modes !== want.lpt_modes)
         report_mismatch("lpt_modes", 80'(got.lpt_modes), 80'(want.lpt_modes));
      if (got.uart_a_base !== want.uart_a_base)
         report_mismatch("uart_a_base", 80'(got.uart_a_base), 80'(want.uart_a_base));
      if (got.uart_a_irq !== want.uart_a_irq)
         report_mismatch("uart_a_irq", 80'(got.uart_a_irq), 80'(want.uart_a_irq));
      if (got.uart_b_base !== want.uart_b_base)
         report_mismatch("uart_b_base", 80'(got.uart_b_base), 80'(want.uart_b_base));
      if (got.uart_b_irq !== want.uart_b_irq)
         report_mismatch("uart_b_irq", 80'(got.uart_b_irq), 80'(want.uart_b_irq));
      if (got.fdc_base !== want.fdc_base)
         report_mismatch("fdc_base", 80'(got.fdc_base), 80'(want.fdc_base));
      if (got.ide_base !== want.ide_base)
         report_mismatch("ide_base", 80'(got.ide_base), 80'(want.ide_base));
   endtask

   // Receiver: checks each rsp_ transaction, then picks next cycle's ready.
   // A long hold-off is requested by bumping hold_token and counted down here.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_reply(rsp_tdata);
         if (hold_token != hold_seen) begin
            hold_seen  = hold_token;
            stall_left = LongHold;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------------
   // One host access; the reply is predicted at the edge that takes it.
   task automatic send_access(input logic act, input logic port,
                              input byte_type wdata);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= {port, act};
      req_tdata  <= wdata;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      access_replies.push_back(host_access(act, port, wdata));
      accesses_sent++;
   endtask

   // sender goes quiet until every owed reply is back
   task automatic settle_replies();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (access_replies.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // strap write: only ever issued with the block idle
   task automatic write_strap(input logic [CsrIndexWidth-1:0] idx,
                              input logic [CsrDataWidth-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_CHIP_VARIANT: begin
            strap_large = val[0];
            reload_defaults();
         end
         CSR_IDE_CHANNEL: begin
            strap_ide = val;
            reload_defaults();
         end
         CSR_FDC_ON: begin
            strap_fdc = val[0];
            reload_defaults();
         end
         default: ;   // outside the list: no effect
      endcase
      strap_writes++;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // defaults straight out of reset, pointer extremes, register 8 and the
   // 0xFF returned beyond the readable range
   task automatic test_power_on_reads();
      send_access(ACT_READ,  PORT_INDEX, 8'h00);
      send_access(ACT_READ,  PORT_DATA,  8'hFF);
      send_access(ACT_WRITE, PORT_INDEX, 8'hFF);   // upper bits dropped, pointer 31
      send_access(ACT_READ,  PORT_INDEX, 8'h00);
      send_access(ACT_READ,  PORT_DATA,  8'h00);
      send_access(ACT_WRITE, PORT_INDEX, {3'b000, PTR_READ_ONLY});
      send_access(ACT_READ,  PORT_DATA,  8'h00);
   endtask

   // the two-write unlock: read-only target, a read breaking the pair,
   // an index write breaking the pair, power-down and all-ones port select
   task automatic test_guarded_writes();
      send_access(ACT_WRITE, PORT_DATA,  8'h00);
      send_access(ACT_WRITE, PORT_DATA,  8'h00);   // dropped, register 8
      send_access(ACT_WRITE, PORT_INDEX, 8'h02);
      send_access(ACT_WRITE, PORT_DATA,  8'hFF);
      send_access(ACT_READ,  PORT_DATA,  8'h00);   // read clears the unlock
      send_access(ACT_WRITE, PORT_DATA,  8'h81);
      send_access(ACT_WRITE, PORT_DATA,  8'h81);   // power down + extended mode
      send_access(ACT_READ,  PORT_DATA,  8'h00);
      send_access(ACT_WRITE, PORT_INDEX, 8'h01);
      send_access(ACT_WRITE, PORT_DATA,  8'hFF);
      send_access(ACT_WRITE, PORT_DATA,  8'hFF);   // no parallel port, alt serial
      send_access(ACT_WRITE, PORT_DATA,  8'h00);
      send_access(ACT_WRITE, PORT_INDEX, 8'h01);   // index write clears the unlock
      send_access(ACT_WRITE, PORT_DATA,  8'h00);
      send_access(ACT_READ,  PORT_DATA,  8'h00);   // still 0xFF
   endtask

   // Mostly proper unlock sequences with random pointer and data, plus
   // broken pairs and plain noise. Count is approximate.
   task automatic test_random_traffic(input int n_items);
      int         sent;
      int         kind;
      logic [4:0] ptr;
      sent = 0;
      while (sent < n_items) begin
         kind = $urandom_range(99);
         ptr  = ($urandom_range(9) < 8) ? 5'($urandom_range(9)) : 5'($urandom);
         if (kind < 65) begin
            send_access(ACT_WRITE, PORT_INDEX, {3'($urandom), ptr});
            send_access(ACT_WRITE, PORT_DATA,  8'($urandom));
            send_access(ACT_WRITE, PORT_DATA,  8'($urandom));
            send_access(ACT_READ,  PORT_DATA,  8'($urandom));
            sent += 4;
            if ($urandom_range(3) == 0) begin
               send_access(ACT_READ, PORT_INDEX, 8'($urandom));
               sent++;
            end
         end else if (kind < 80) begin
            // pair interrupted by some other transaction
            send_access(ACT_WRITE, PORT_INDEX, {3'($urandom), ptr});
            send_access(ACT_WRITE, PORT_DATA,  8'($urandom));
            send_access(1'($urandom), 1'($urandom), 8'($urandom));
            send_access(ACT_WRITE, PORT_DATA,  8'($urandom));
            sent += 4;
         end else begin
            send_access(1'($urandom), 1'($urandom), 8'($urandom));
            sent++;
         end
      end
   endtask

   // receiver holds off while the sender keeps offering: the output stage
   // fills and req_tready has to drop
   task automatic test_backpressure();
      hold_token <= hold_token + 1;
      test_random_traffic(30);
   endtask

   // sender stops mid-stream until every reply is home, then carries on
   task automatic test_quiet_pause();
      test_random_traffic(45);
      settle_replies();
      test_random_traffic(45);
   endtask

   initial begin
      strap_large = 1'b0;
      strap_ide   = IDE_NONE;
      strap_fdc   = 1'b1;
      reload_defaults();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sender idles now and then, receiver mostly stalled
      send_idle_pct = 15;
      recv_idle_pct <= 79;
      test_power_on_reads();
      test_guarded_writes();
      settle_replies();

      write_strap(CSR_CHIP_VARIANT, 2'b11);
      write_strap(CSR_IDE_CHANNEL, IDE_SECONDARY);
      write_strap(CSR_FDC_ON, 2'b01);
      test_random_traffic(130);
      settle_replies();

      // roles swapped
      send_idle_pct = 79;
      recv_idle_pct <= 15;
      write_strap(CSR_IDE_CHANNEL, IDE_PRIMARY);
      write_strap(CSR_FDC_ON, 2'b10);
      test_random_traffic(130);
      settle_replies();

      // no idling from here on
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      test_backpressure();
      settle_replies();

      write_strap(CSR_CHIP_VARIANT, 2'b10);
      write_strap(CSR_IDE_CHANNEL, IDE_INVALID);
      write_strap(CSR_UNUSED, 2'b01);
      test_quiet_pause();
      settle_replies();

      write_strap(CSR_IDE_CHANNEL, IDE_NONE);
      write_strap(CSR_FDC_ON, 2'b11);
      test_random_traffic(50);
      settle_replies();

      repeat (4) @(posedge clock);
      if (access_replies.size() != 0)
         report_mismatch("replies never returned", 80'(access_replies.size()), '0);

      $display("Covered %0d host accesses and %0d replies over %0d strap writes,",
               accesses_sent, replies_seen, strap_writes);
      $display("both chip variants, every IDE code, idle mixes and a %0d-cycle stall.",
               LongHold);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
